FILE: src/gait_bridge_path_walker_unit_assert.svh
`ifndef GAIT_BRIDGE_PATH_WALKER_UNIT_ASSERT_SVH
`define GAIT_BRIDGE_PATH_WALKER_UNIT_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define GBPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define GBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gbpw_pkg.sv
package gbpw_pkg;

  localparam int ID_W     = 6;
  localparam int MASK_W   = 64;
  localparam int CFG_W    = 7;
  localparam int STATUS_W = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PATH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BROKEN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITE  = 3'd4;

  localparam logic [CFG_W-1:0] MAX_BRIDGES_RST = 7'd4;

  typedef struct packed {
    logic              present;
    logic [ID_W-1:0]   bridge;
    logic [MASK_W-1:0] mask;
  } gbpw_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ONE,
    S_PREP,
    S_EMIT
  } gbpw_state_t;

endpackage

FILE: src/gait_bridge_path_walker_unit.sv
// channel  | dir | handshake                | payload
// in_      | in  | in_tvalid / in_tready    | tuser req_type, tdata goal/entry fields
// out_     | out | out_tvalid / out_tready  | tdata gait_out, tlast last, tuser status
// cfg_     | in  | cfg_valid / cfg_ready    | cfg_data max_bridges
//
// one item at a time; a write goes to S_ONE, which emits its acknowledge
// a query does one table read per visited table entry, then sets up the path buffer read
// in S_PREP and emits the path items one by one; a failure gives one item
// results sit in an output register, downstream stalls hold the emitter in place
// rst_n is synchronous: all table entries become absent, max_bridges returns to 4
`include "gait_bridge_path_walker_unit_assert.svh"

module gait_bridge_path_walker_unit import gbpw_pkg::*; #(
  parameter int NUM_GAITS = 64,
  parameter int MAX_PATH  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [5:0] gait_id, [11:6] cur_id, [12] entry_present, [18:13] bridge_id,
  // [82:19] neighbor_mask, [87:83] zero
  input  logic [87:0]      in_tdata,
  // [0] req_type
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [5:0] gait_out, [7:6] zero
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  // [2:0] status
  output logic [2:0]       out_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(NUM_GAITS);
  localparam int PW = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
  localparam int LW = $clog2(MAX_PATH + 1);

  // input fields
  logic [ID_W-1:0]   in_gait_id;
  logic [ID_W-1:0]   in_cur;
  logic              in_present;
  logic [ID_W-1:0]   in_bridge;
  logic [MASK_W-1:0] in_mask;
  logic              in_id_ok;

  assign in_gait_id = in_tdata[5:0];
  assign in_cur     = in_tdata[11:6];
  assign in_present = in_tdata[12];
  assign in_bridge  = in_tdata[18:13];
  assign in_mask    = in_tdata[82:19];
  assign in_id_ok   = ({1'b0, in_gait_id} < (ID_W+1)'(NUM_GAITS));

  // registers
  gbpw_state_t         state_r, state_nxt;
  logic [CFG_W-1:0]    max_bridges_r;
  logic [LW-1:0]       limit_r, limit_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       plen_r, plen_nxt;
  logic [LW-1:0]       k_r, k_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ID_W-1:0]     cur_r, cur_nxt;
  logic [ID_W-1:0]     res_gait_r, res_gait_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_gait_r, out_gait_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // table and path buffer ports
  logic          tbl_we;
  gbpw_entry_t   tbl_wentry;
  logic          tbl_re;
  logic [AW-1:0] tbl_raddr;
  gbpw_entry_t   tbl_rentry;

  logic            pb_we;
  logic [PW-1:0]   pb_waddr;
  logic            pb_re;
  logic [PW-1:0]   pb_raddr;
  logic [ID_W-1:0] pbuf [MAX_PATH];
  logic [ID_W-1:0] pb_q_r;

  logic          out_free;
  logic [LW-1:0] len_inc;
  logic [LW-1:0] k_inc;
  logic [LW-1:0] lim_calc;
  logic          bridge_ok;
  logic          emit_last;
  logic          wr_take;
  logic          emit_idx_ok;
  logic          ack_pend;

  assign out_free  = !out_valid_r || out_tready;
  assign len_inc   = len_r + LW'(1);
  assign k_inc     = k_r + LW'(1);
  assign emit_last = (k_inc == plen_r);
  assign lim_calc  = (max_bridges_r > CFG_W'(MAX_PATH)) ? LW'(MAX_PATH) : LW'(max_bridges_r);
  assign bridge_ok = ({1'b0, tbl_rentry.bridge} < (ID_W+1)'(NUM_GAITS));

  assign tbl_wentry.present = in_present;
  assign tbl_wentry.bridge  = in_bridge;
  assign tbl_wentry.mask    = in_mask;

  gbpw_table #(
    .NUM_GAITS (NUM_GAITS),
    .AW        (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_addr  (in_gait_id[AW-1:0]),
    .wr_entry (tbl_wentry),
    .rd_en    (tbl_re),
    .rd_addr  (tbl_raddr),
    .rd_entry (tbl_rentry)
  );

  // path buffer: written during the walk, read back while emitting
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pbuf[pb_waddr] <= id_r;
    end
    if (pb_re) begin
      pb_q_r <= pbuf[pb_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    len_nxt        = len_r;
    plen_nxt       = plen_r;
    k_nxt          = k_r;
    id_nxt         = id_r;
    cur_nxt        = cur_r;
    res_gait_nxt   = res_gait_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_gait_nxt   = out_gait_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    tbl_raddr      = in_gait_id[AW-1:0];
    pb_we          = 1'b0;
    pb_waddr       = len_r[PW-1:0];
    pb_re          = 1'b0;
    pb_raddr       = k_r[PW-1:0];
    in_tready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_WRITE) begin
            tbl_we         = in_id_ok;
            res_gait_nxt   = in_gait_id;
            res_status_nxt = ST_WRITE;
            state_nxt      = S_ONE;
          end else begin
            limit_nxt = lim_calc;
            cur_nxt   = in_cur;
            id_nxt    = in_gait_id;
            len_nxt   = '0;
            if (!in_id_ok || (max_bridges_r == '0)) begin
              res_gait_nxt   = '0;
              res_status_nxt = ST_ABSENT;
              state_nxt      = S_ONE;
            end else begin
              tbl_re    = 1'b1;
              state_nxt = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        res_gait_nxt = '0;
        if (!tbl_rentry.present) begin
          // goal itself absent, or a bridge led to an absent entry
          res_status_nxt = (len_r == '0) ? ST_ABSENT : ST_BROKEN;
          state_nxt      = S_ONE;
        end else begin
          pb_we   = 1'b1;
          len_nxt = len_inc;
          priority if (tbl_rentry.mask[cur_r]) begin
            plen_nxt  = len_inc;
            k_nxt     = '0;
            state_nxt = S_PREP;
          end else if (len_inc >= limit_r) begin
            res_status_nxt = ST_LIMIT;
            state_nxt      = S_ONE;
          end else if (!bridge_ok) begin
            res_status_nxt = ST_BROKEN;
            state_nxt      = S_ONE;
          end else begin
            id_nxt    = tbl_rentry.bridge;
            tbl_re    = 1'b1;
            tbl_raddr = tbl_rentry.bridge[AW-1:0];
          end
        end
      end

      S_PREP: begin
        pb_re     = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_gait_nxt   = pb_q_r;
          out_last_nxt   = emit_last;
          out_status_nxt = ST_PATH;
          k_nxt          = k_inc;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            pb_re    = 1'b1;
            pb_raddr = k_inc[PW-1:0];
          end
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_gait_nxt   = res_gait_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      max_bridges_r <= MAX_BRIDGES_RST;
      limit_r       <= '0;
      len_r         <= '0;
      plen_r        <= '0;
      k_r           <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
      len_r       <= len_nxt;
      plen_r      <= plen_nxt;
      k_r         <= k_nxt;
      if (cfg_valid) begin
        max_bridges_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    cur_r        <= cur_nxt;
    res_gait_r   <= res_gait_nxt;
    res_status_r <= res_status_nxt;
    out_gait_r   <= out_gait_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_gait_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  assign wr_take     = in_tvalid && in_tready && (in_tuser == REQ_WRITE);
  assign emit_idx_ok = (plen_r != '0) && (k_r < plen_r);
  assign ack_pend    = (state_r == S_ONE) && (res_status_r == ST_WRITE);

  `GBPW_ASSERT_NOW(a_walk_lim, clk, rst_n, state_r == S_WALK, len_r < limit_r, "walk past limit")
  `GBPW_ASSERT_NOW(a_emit_idx, clk, rst_n, state_r == S_EMIT, emit_idx_ok, "bad emit index")
  `GBPW_ASSERT_NEXT(a_write_ack, clk, rst_n, wr_take, ack_pend, "write item not acknowledged")

endmodule

FILE: src/gbpw_table.sv
module gbpw_table import gbpw_pkg::*; #(
  parameter int NUM_GAITS = 64,
  parameter int AW = $clog2(NUM_GAITS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  gbpw_entry_t   wr_entry,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output gbpw_entry_t   rd_entry
);

  // present flags live in flops so reset clears every entry at once
  logic [NUM_GAITS-1:0]     present_r;
  logic [ID_W+MASK_W-1:0]   mem [NUM_GAITS];
  logic                     rd_present_r;
  logic [ID_W+MASK_W-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr_en) begin
      present_r[wr_addr] <= wr_entry.present;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_entry.bridge, wr_entry.mask};
    end
    if (rd_en) begin
      rd_data_r    <= mem[rd_addr];
      rd_present_r <= present_r[rd_addr];
    end
  end

  assign rd_entry.present = rd_present_r;
  assign rd_entry.bridge  = rd_data_r[ID_W+MASK_W-1:MASK_W];
  assign rd_entry.mask    = rd_data_r[MASK_W-1:0];

endmodule
